// ===== rtl/sfba_pkg.sv =====
// shared types, widths and codes of the segregated free-list bump allocator
// no dependencies; every other file of the block imports this package

package sfba_pkg;

	// default parameter values
	localparam int unsigned ARENA_BYTES_DEF  = 1048576;
	localparam int unsigned ALIGN_BYTES_DEF  = 16;
	localparam int unsigned MAX_WORDS_DEF    = 64;
	localparam int unsigned HEADER_BYTES_DEF = 1024;
	localparam int unsigned WORD_BYTES_DEF   = 8;

	// field widths
	localparam int OP_W       = 2;
	localparam int WORDS_W    = 18;
	localparam int OFF_W      = 20;
	localparam int ADDR_W     = 20;
	localparam int STAT_W     = 3;
	localparam int BYTES_W    = 21;
	localparam int CNT_W      = 17;
	localparam int PAY_W      = 22;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARENA = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_STATS   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_REUSED   = 3'd0,
		ST_BUMPED   = 3'd1,
		ST_OOM      = 3'd2,
		ST_LISTED   = 3'd3,
		ST_ABANDON  = 3'd4,
		ST_NULL     = 3'd5,
		ST_CLEARED  = 3'd6,
		ST_RESERVED = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_LINK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic link_rd;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop;
		logic out_stall;
	} sts_t;

	// one row of the per-class table
	typedef struct packed {
		logic [ADDR_W-1:0] head;
		logic [CNT_W-1:0]  live;
		logic [CNT_W-1:0]  peak;
	} row_t;

	// bump limit in force: smaller of the register and the arena parameter
	function automatic logic [BYTES_W-1:0] limit_of(logic [BYTES_W-1:0] arena,
		int unsigned arena_param);
		logic [BYTES_W-1:0] res;
		if (32'(arena) < arena_param) begin
			res = arena;
		end else begin
			res = BYTES_W'(arena_param);
		end
		return res;
	endfunction

endpackage

// ===== rtl/sfba_req_if.sv =====
// request channel of the allocator: valid/ready plus the request fields
// depends on sfba_pkg

interface sfba_req_if;
	import sfba_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [WORDS_W-1:0] words;
	logic [OFF_W-1:0]   block_offset;

	modport source(output valid, output operation, output words, output block_offset,
		input ready);
	modport sink(input valid, input operation, input words, input block_offset,
		output ready);
endinterface

// ===== rtl/sfba_rsp_if.sv =====
// response channel of the allocator: valid/ready plus the result fields
// depends on sfba_pkg

interface sfba_rsp_if;
	import sfba_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  address;
	logic [STAT_W-1:0]  status;
	logic [BYTES_W-1:0] live_total;
	logic [BYTES_W-1:0] peak_total;
	logic [BYTES_W-1:0] listed_total;
	logic [CNT_W-1:0]   class_live;
	logic [CNT_W-1:0]   class_peak;

	modport source(output valid, output address, output status, output live_total,
		output peak_total, output listed_total, output class_live, output class_peak,
		input ready);
	modport sink(input valid, input address, input status, input live_total,
		input peak_total, input listed_total, input class_live, input class_peak,
		output ready);
endinterface

// ===== rtl/segregated_freelist_bump_allocator.sv =====
// top level of the segregated free-list bump allocator: config registers and wiring
// depends on sfba_pkg, sfba_req_if, sfba_rsp_if, sfba_ctrl, sfba_dp
//
// Usage: requests arrive on req (allocate, release, reset of peak statistics, no-op)
// and each produces exactly one result item on rsp. Both are valid/ready channels; an
// item moves on a clock edge with valid and ready high. mode and arena_bytes are
// written through cfg_we/cfg_index/cfg_data; the user must do so only while no
// request is in flight, which the block itself does not enforce. An accepted request
// has its class-table row read as it is taken; an allocate served from a free list
// then reads the link of the list head from the link memory; the item then finishes
// with its counter update and its registered result. The block takes one item at a
// time. Back to back, a new item is taken in the cycle after the previous result is
// registered. A stalled rsp holds its result; the block finishes no new item until
// it is taken. Reset clears the live, peak and listed counters, sets the bump pointer
// to HEADER_BYTES, empties all lists (per-class valid bits, no sweep) and restores
// mode 1 and the full arena. ARENA_BYTES and ALIGN_BYTES are powers of two.

module segregated_freelist_bump_allocator #(
	parameter int unsigned ARENA_BYTES  = sfba_pkg::ARENA_BYTES_DEF,
	parameter int unsigned ALIGN_BYTES  = sfba_pkg::ALIGN_BYTES_DEF,
	parameter int unsigned MAX_WORDS    = sfba_pkg::MAX_WORDS_DEF,
	parameter int unsigned HEADER_BYTES = sfba_pkg::HEADER_BYTES_DEF,
	parameter int unsigned WORD_BYTES   = sfba_pkg::WORD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sfba_req_if.sink                          req,
	sfba_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [sfba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfba_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sfba_pkg::*;

	localparam logic [BYTES_W-1:0] LIMIT_RST = limit_of(BYTES_W'(ARENA_BYTES), ARENA_BYTES);

	logic               mode_q;
	logic [BYTES_W-1:0] limit_q;
	cmd_t               cmd;
	sts_t               sts;
	logic               req_ready;

	// the limit is clamped when written, so the datapath sees it ready to compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == CFG_ARENA) begin
				limit_q <= limit_of(cfg_data[BYTES_W-1:0], ARENA_BYTES);
			end
		end
	end

	sfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sfba_dp #(
		.ARENA_BYTES  (ARENA_BYTES),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.MAX_WORDS    (MAX_WORDS),
		.HEADER_BYTES (HEADER_BYTES),
		.WORD_BYTES   (WORD_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (mode_q),
		.limit        (limit_q),
		.operation    (req.operation),
		.words        (req.words),
		.block_offset (req.block_offset),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.address      (rsp.address),
		.status       (rsp.status),
		.live_total   (rsp.live_total),
		.peak_total   (rsp.peak_total),
		.listed_total (rsp.listed_total),
		.class_live   (rsp.class_live),
		.class_peak   (rsp.class_peak)
	);

	assign req.ready = req_ready;

endmodule

// ===== rtl/sfba_ctrl.sv =====
// sequencing state machine of the allocator: accept, table read, link read, finish
// depends on sfba_pkg; drives the datapath through cmd_t and reads sts_t

module sfba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sfba_pkg::sts_t sts,
	output sfba_pkg::cmd_t cmd
);
	import sfba_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				if (sts.pop) begin
					state_nxt = S_LINK;
				end else if (!sts.out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			S_LINK: begin
				if (!sts.out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.load    = 1'b0;
		cmd.link_rd = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_READ: begin
				// a pop needs the link of the list head before it can finish
				cmd.link_rd = sts.pop;
				cmd.finish  = !sts.pop && !sts.out_stall;
			end
			S_LINK: begin
				cmd.finish = !sts.out_stall;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_load_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_READ)
		else $error("accepted item did not move to the table read");
	a_link_to_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_rd |=> state_q == S_LINK && !cmd.load)
		else $error("link read not followed by the link state");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE && !cmd.finish)
		else $error("finish did not return to idle");
`endif

endmodule

// ===== rtl/sfba_dp.sv =====
// datapath of the allocator: class table, link memory, byte counters, result register
// depends on sfba_pkg; sequenced by sfba_ctrl through cmd_t / sts_t

module sfba_dp #(
	parameter int unsigned ARENA_BYTES  = sfba_pkg::ARENA_BYTES_DEF,
	parameter int unsigned ALIGN_BYTES  = sfba_pkg::ALIGN_BYTES_DEF,
	parameter int unsigned MAX_WORDS    = sfba_pkg::MAX_WORDS_DEF,
	parameter int unsigned HEADER_BYTES = sfba_pkg::HEADER_BYTES_DEF,
	parameter int unsigned WORD_BYTES   = sfba_pkg::WORD_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sfba_pkg::cmd_t                   cmd,
	output sfba_pkg::sts_t                   sts,
	input  logic                             mode,
	input  logic [sfba_pkg::BYTES_W-1:0]     limit,
	input  logic [sfba_pkg::OP_W-1:0]        operation,
	input  logic [sfba_pkg::WORDS_W-1:0]     words,
	input  logic [sfba_pkg::OFF_W-1:0]       block_offset,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [sfba_pkg::ADDR_W-1:0]      address,
	output logic [sfba_pkg::STAT_W-1:0]      status,
	output logic [sfba_pkg::BYTES_W-1:0]     live_total,
	output logic [sfba_pkg::BYTES_W-1:0]     peak_total,
	output logic [sfba_pkg::BYTES_W-1:0]     listed_total,
	output logic [sfba_pkg::CNT_W-1:0]       class_live,
	output logic [sfba_pkg::CNT_W-1:0]       class_peak
);
	import sfba_pkg::*;

	localparam int unsigned CLASS_COUNT = MAX_WORDS + 1;
	localparam int CLS_W = $clog2(CLASS_COUNT);
	localparam int ALIGN_LG = $clog2(ALIGN_BYTES);
	// offsets are 20 bits, so slots above the offset span are never reached
	localparam int unsigned LINK_FULL = ARENA_BYTES / ALIGN_BYTES;
	localparam int unsigned LINK_SPAN = (1 << ADDR_W) / ALIGN_BYTES;
	localparam int unsigned LINK_DEPTH = (LINK_FULL < LINK_SPAN) ? LINK_FULL : LINK_SPAN;
	localparam int LINK_W = $clog2(LINK_DEPTH);
	localparam logic [PAY_W-1:0] ALIGN_MASK = ~(PAY_W'(ALIGN_BYTES - 1));
	localparam logic [PAY_W-1:0] ALIGN_ADD = PAY_W'(ALIGN_BYTES - 1);
	localparam logic [WORDS_W-1:0] SMALL_MAX = WORDS_W'(MAX_WORDS);
	localparam logic [BYTES_W-1:0] BUMP_RST = BYTES_W'(HEADER_BYTES);

	// request registers
	op_t                op_q;
	logic               small_q;
	logic [PAY_W-1:0]   payload_q;
	logic [OFF_W-1:0]   offset_q;
	logic [CLS_W-1:0]   cls_q;

	// class table and link memory
	row_t               row_mem [CLASS_COUNT];
	logic [CLASS_COUNT-1:0] row_vld_q;
	logic [CLASS_COUNT-1:0] peak_vld_q;
	row_t               row_q;
	logic               rvld_q;
	logic               pvld_q;
	logic [ADDR_W-1:0]  link_mem [LINK_DEPTH];
	logic [ADDR_W-1:0]  link_q;

	// global counters
	logic [BYTES_W-1:0] bump_q;
	logic [BYTES_W-1:0] live_q;
	logic [BYTES_W-1:0] peak_q;
	logic [BYTES_W-1:0] listed_q;

	// result register
	logic               rsp_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	status_t            status_q;
	logic [BYTES_W-1:0] live_out_q;
	logic [BYTES_W-1:0] peak_out_q;
	logic [BYTES_W-1:0] listed_out_q;
	logic [CNT_W-1:0]   cls_live_q;
	logic [CNT_W-1:0]   cls_peak_q;

	logic               small_in;
	logic [CLS_W-1:0]   rd_idx;
	logic [PAY_W-1:0]   raw_bytes;
	logic [PAY_W-1:0]   payload_in;

	logic [ADDR_W-1:0]  head_e;
	logic [CNT_W-1:0]   live_e;
	logic [CNT_W-1:0]   peak_e;
	logic [CNT_W-1:0]   live_inc;
	logic [CNT_W-1:0]   peak_inc;
	logic [PAY_W:0]     bump_sum;
	logic               fail;
	logic               pop;
	logic [BYTES_W-1:0] live_plus;
	logic [BYTES_W-1:0] live_minus;
	logic [BYTES_W-1:0] peak_plus;
	logic [BYTES_W-1:0] listed_plus;
	logic [BYTES_W-1:0] listed_minus;

	logic [BYTES_W-1:0] bump_n;
	logic [BYTES_W-1:0] live_n;
	logic [BYTES_W-1:0] peak_n;
	logic [BYTES_W-1:0] listed_n;
	logic [ADDR_W-1:0]  head_n;
	logic [CNT_W-1:0]   cls_live_n;
	logic [CNT_W-1:0]   cls_peak_n;
	logic               row_we;
	logic               link_we;
	logic               peak_clr;
	logic [ADDR_W-1:0]  addr_n;
	status_t            status_n;

	// request decode at accept
	always_comb begin
		small_in   = words <= SMALL_MAX;
		rd_idx     = small_in ? words[CLS_W-1:0] : '0;
		raw_bytes  = PAY_W'(words) * PAY_W'(WORD_BYTES);
		payload_in = (raw_bytes + ALIGN_ADD) & ALIGN_MASK;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op_t'(operation);
			small_q   <= small_in;
			payload_q <= payload_in;
			offset_q  <= block_offset;
			cls_q     <= rd_idx;
		end
	end

	// class table: read at accept, written when the item finishes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q  <= row_mem[rd_idx];
			rvld_q <= row_vld_q[rd_idx];
			pvld_q <= peak_vld_q[rd_idx];
		end
		if (cmd.finish && row_we) begin
			row_mem[cls_q] <= '{head: head_n, live: cls_live_n, peak: cls_peak_n};
		end
	end

	// link memory: read of the head's link, written by a listed release
	always_ff @(posedge clk) begin
		if (cmd.link_rd) begin
			link_q <= link_mem[head_e[ALIGN_LG +: LINK_W]];
		end
		if (cmd.finish && link_we) begin
			link_mem[offset_q[ALIGN_LG +: LINK_W]] <= head_e;
		end
	end

	// rows never written read as empty list and zero counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			peak_vld_q <= '0;
		end else if (cmd.finish) begin
			if (peak_clr) begin
				peak_vld_q <= '0;
			end else if (row_we) begin
				row_vld_q[cls_q]  <= 1'b1;
				peak_vld_q[cls_q] <= 1'b1;
			end
		end
	end

	always_comb begin
		head_e   = rvld_q ? row_q.head : '0;
		live_e   = rvld_q ? row_q.live : '0;
		peak_e   = (rvld_q && pvld_q) ? row_q.peak : '0;
		live_inc = live_e + CNT_W'(1);
		peak_inc = (live_inc > peak_e) ? live_inc : peak_e;
		bump_sum = (PAY_W + 1)'(bump_q) + (PAY_W + 1)'(payload_q);
		fail     = bump_sum > (PAY_W + 1)'(limit);
		pop      = (op_q == OP_ALLOC) && mode && small_q && (head_e != '0);

		live_plus    = live_q + payload_q[BYTES_W-1:0];
		live_minus   = live_q - payload_q[BYTES_W-1:0];
		peak_plus    = (live_plus > peak_q) ? live_plus : peak_q;
		listed_plus  = listed_q + payload_q[BYTES_W-1:0];
		listed_minus = listed_q - payload_q[BYTES_W-1:0];
	end

	always_comb begin
		bump_n     = bump_q;
		live_n     = live_q;
		peak_n     = peak_q;
		listed_n   = listed_q;
		head_n     = head_e;
		cls_live_n = live_e;
		cls_peak_n = peak_e;
		row_we     = 1'b0;
		link_we    = 1'b0;
		peak_clr   = 1'b0;
		addr_n     = '0;
		status_n   = ST_NULL;
		unique case (op_q)
			OP_ALLOC: begin
				// class live and peak are raised before the space check
				row_we     = small_q;
				cls_live_n = live_inc;
				cls_peak_n = peak_inc;
				if (pop) begin
					head_n   = link_q;
					listed_n = listed_minus;
					live_n   = live_plus;
					peak_n   = peak_plus;
					addr_n   = head_e;
					status_n = ST_REUSED;
				end else if (fail) begin
					// live count falls back, the raised peak stays
					cls_live_n = live_e;
					status_n   = ST_OOM;
				end else begin
					addr_n   = bump_q[ADDR_W-1:0];
					bump_n   = bump_sum[BYTES_W-1:0];
					live_n   = live_plus;
					peak_n   = peak_plus;
					status_n = ST_BUMPED;
				end
			end
			OP_RELEASE: begin
				if (offset_q != '0) begin
					live_n     = live_minus;
					row_we     = small_q;
					cls_live_n = live_e - CNT_W'(1);
					if (!mode || !small_q) begin
						status_n = ST_ABANDON;
					end else begin
						link_we  = 1'b1;
						head_n   = offset_q;
						listed_n = listed_plus;
						status_n = ST_LISTED;
					end
				end
			end
			OP_STATS: begin
				peak_n     = live_q;
				peak_clr   = 1'b1;
				cls_peak_n = '0;
				status_n   = ST_CLEARED;
			end
			OP_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q      <= BUMP_RST;
			live_q      <= '0;
			peak_q      <= '0;
			listed_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				bump_q      <= bump_n;
				live_q      <= live_n;
				peak_q      <= peak_n;
				listed_q    <= listed_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			addr_q       <= addr_n;
			status_q     <= status_n;
			live_out_q   <= live_n;
			peak_out_q   <= peak_n;
			listed_out_q <= listed_n;
			cls_live_q   <= small_q ? cls_live_n : '0;
			cls_peak_q   <= small_q ? cls_peak_n : '0;
		end
	end

	assign sts.pop       = pop;
	assign sts.out_stall = rsp_valid_q && !rsp_ready;

	assign rsp_valid    = rsp_valid_q;
	assign address      = addr_q;
	assign status       = status_q;
	assign live_total   = live_out_q;
	assign peak_total   = peak_out_q;
	assign listed_total = listed_out_q;
	assign class_live   = cls_live_q;
	assign class_peak   = cls_peak_q;

`ifndef SYNTHESIS
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q)
		else $error("finished item not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid_q && !rsp_ready))
		else $error("result register overwritten while stalled");
	a_reuse_nonnull: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_REUSED |-> addr_q != '0)
		else $error("reused block with null address");
	a_link_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_rd |-> op_q == OP_ALLOC && small_q && mode)
		else $error("link read outside a free-list pop");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of segregated_freelist_bump_allocator
// depends on sfba_pkg, sfba_req_if, sfba_rsp_if and the allocator rtl
// a scoreboard class keeps its own allocator state and checks every result item

module tb_top;
	import sfba_pkg::*;

	localparam int unsigned ARENA      = ARENA_BYTES_DEF;
	localparam int unsigned ALIGN      = ALIGN_BYTES_DEF;
	localparam int unsigned MAX_WORDS  = MAX_WORDS_DEF;
	localparam int unsigned HEADER     = HEADER_BYTES_DEF;
	localparam int unsigned WORD       = WORD_BYTES_DEF;
	localparam int unsigned CLASSES    = MAX_WORDS + 1;
	localparam int unsigned LINK_DEPTH = ARENA / ALIGN;
	localparam int unsigned PHASE_ITEMS = 100;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		status_t            status;
		logic [BYTES_W-1:0] live_total;
		logic [BYTES_W-1:0] peak_total;
		logic [BYTES_W-1:0] listed_total;
		logic [CNT_W-1:0]   class_live;
		logic [CNT_W-1:0]   class_peak;
	} alloc_result_t;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [WORDS_W-1:0] words;
	} held_block_t;

	class alloc_ledger;
		bit                 mode;
		logic [BYTES_W-1:0] arena;
		logic [BYTES_W-1:0] bump;
		logic [BYTES_W-1:0] live;
		logic [BYTES_W-1:0] peak;
		logic [BYTES_W-1:0] listed;
		logic [ADDR_W-1:0]  heads [CLASSES];
		logic [ADDR_W-1:0]  links [LINK_DEPTH];
		logic [CNT_W-1:0]   cls_live [CLASSES];
		logic [CNT_W-1:0]   cls_peak [CLASSES];
		alloc_result_t      awaited [$];
		int unsigned        failures;

		function new();
			mode = 1'b1;
			arena = BYTES_W'(ARENA);
			bump = BYTES_W'(HEADER);
			live = '0;
			peak = '0;
			listed = '0;
			failures = 0;
			foreach (heads[c]) begin
				heads[c] = '0;
				cls_live[c] = '0;
				cls_peak[c] = '0;
			end
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_MODE) begin
				mode = data[0];
			end else begin
				arena = data;
			end
		endfunction

		function void grow_live(int unsigned pay);
			live = live + BYTES_W'(pay);
			if (live > peak) begin
				peak = live;
			end
		endfunction

		// applies one accepted request and queues the result it must produce
		function alloc_result_t note_request(op_t op, logic [WORDS_W-1:0] w,
			logic [OFF_W-1:0] off);
			alloc_result_t r;
			bit            sized;
			int unsigned   pay;
			int unsigned   lim;
			sized = (w <= MAX_WORDS);
			pay = (32'(w) * WORD + ALIGN - 1) / ALIGN * ALIGN;
			r = '0;
			r.status = ST_NULL;
			case (op)
				OP_ALLOC: begin
					lim = (32'(arena) < ARENA) ? 32'(arena) : ARENA;
					// class peak moves even if the allocate fails later
					if (sized) begin
						cls_live[w] = cls_live[w] + 1'b1;
						if (cls_live[w] > cls_peak[w]) begin
							cls_peak[w] = cls_live[w];
						end
					end
					if (mode && sized && heads[w] != '0) begin
						r.address = heads[w];
						heads[w] = links[(32'(r.address) / ALIGN) % LINK_DEPTH];
						listed = listed - BYTES_W'(pay);
						grow_live(pay);
						r.status = ST_REUSED;
					end else if (32'(bump) + pay > lim) begin
						if (sized) begin
							cls_live[w] = cls_live[w] - 1'b1;
						end
						r.status = ST_OOM;
					end else begin
						r.address = bump[ADDR_W-1:0];
						bump = bump + BYTES_W'(pay);
						grow_live(pay);
						r.status = ST_BUMPED;
					end
				end
				OP_RELEASE: begin
					if (off != '0) begin
						if (sized) begin
							cls_live[w] = cls_live[w] - 1'b1;
						end
						live = live - BYTES_W'(pay);
						if (!mode || !sized) begin
							r.status = ST_ABANDON;
						end else begin
							links[(32'(off) / ALIGN) % LINK_DEPTH] = heads[w];
							heads[w] = off;
							listed = listed + BYTES_W'(pay);
							r.status = ST_LISTED;
						end
					end
				end
				OP_STATS: begin
					foreach (cls_peak[c]) begin
						cls_peak[c] = '0;
					end
					peak = live;
					r.status = ST_CLEARED;
				end
				default: begin
				end
			endcase
			r.live_total = live;
			r.peak_total = peak;
			r.listed_total = listed;
			if (sized) begin
				r.class_live = cls_live[w];
				r.class_peak = cls_peak[w];
			end
			awaited.push_back(r);
			return r;
		endfunction

		function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
				failures++;
			end
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (awaited.size() == 0) begin
				$error("result item with nothing awaited: address %0d status %0d",
					got.address, got.status);
				failures++;
				return;
			end
			want = awaited.pop_front();
			compare("address", 32'(want.address), 32'(got.address));
			compare("status", 32'(want.status), 32'(got.status));
			compare("live_total", 32'(want.live_total), 32'(got.live_total));
			compare("peak_total", 32'(want.peak_total), 32'(got.peak_total));
			compare("listed_total", 32'(want.listed_total), 32'(got.listed_total));
			compare("class_live", 32'(want.class_live), 32'(got.class_live));
			compare("class_peak", 32'(want.class_peak), 32'(got.class_peak));
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           tx_idle_pct;
	int unsigned           rx_idle_pct;
	alloc_ledger           ledger;
	held_block_t           held_blocks [$];

	sfba_req_if req();
	sfba_rsp_if rsp();

	segregated_freelist_bump_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stalls, every accepted item checked
	always @(posedge clk) begin
		alloc_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.address = rsp.address;
			got.status = status_t'(rsp.status);
			got.live_total = rsp.live_total;
			got.peak_total = rsp.peak_total;
			got.listed_total = rsp.listed_total;
			got.class_live = rsp.class_live;
			got.class_peak = rsp.class_peak;
			ledger.check_result(got);
		end
		rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// sends one request item; called right after a rising edge
	task automatic issue(input op_t op, input logic [WORDS_W-1:0] w,
		input logic [OFF_W-1:0] off);
		alloc_result_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.words <= w;
		req.block_offset <= off;
		do @(posedge clk); while (!req.ready);
		want = ledger.note_request(op, w, off);
		// remember granted blocks so later releases are well formed
		if (op == OP_ALLOC && (want.status == ST_REUSED || want.status == ST_BUMPED)
			&& want.address != '0) begin
			held_blocks.push_back('{want.address, w});
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (ledger.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.configure(idx, data);
	endtask

	function automatic logic [WORDS_W-1:0] pick_words();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 87) begin
			return WORDS_W'($urandom_range(MAX_WORDS));
		end else if (r < 99) begin
			return WORDS_W'($urandom_range(1024, MAX_WORDS + 1));
		end
		return WORDS_W'($urandom_range(131072, 1025));
	endfunction

	task automatic run_phase(input int unsigned count);
		held_block_t        blk;
		int unsigned        pick;
		int unsigned        k;
		logic [WORDS_W-1:0] w;
		logic [OFF_W-1:0]   off;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			w = pick_words();
			off = OFF_W'($urandom);
			if (pick < 45 || (pick < 80 && held_blocks.size() == 0)) begin
				issue(OP_ALLOC, w, off);
			end else if (pick < 80) begin
				k = $urandom_range(held_blocks.size() - 1);
				blk = held_blocks[k];
				held_blocks.delete(k);
				issue(OP_RELEASE, blk.words, blk.addr);
			end else if (pick < 90) begin
				// stray release: random block, sometimes null
				if ($urandom_range(9) == 0) begin
					off = '0;
				end
				issue(OP_RELEASE, w, off);
			end else if (pick < 95) begin
				issue(OP_STATS, w, off);
			end else begin
				issue(OP_NONE, w, off);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_ALLOC;
		req.words = '0;
		req.block_offset = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		tx_idle_pct = 36;
		rx_idle_pct = 55;
		ledger = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset configuration
		issue(OP_ALLOC, 18'd0, 20'd0);
		issue(OP_ALLOC, 18'd1, 20'd0);
		issue(OP_ALLOC, WORDS_W'(MAX_WORDS), 20'd0);
		issue(OP_ALLOC, WORDS_W'(MAX_WORDS + 1), 20'd0);
		issue(OP_RELEASE, 18'd1, OFF_W'(HEADER));
		issue(OP_ALLOC, 18'd1, 20'd0);
		issue(OP_RELEASE, WORDS_W'(MAX_WORDS + 1), OFF_W'(HEADER + 528));
		issue(OP_RELEASE, 18'd2, 20'd0);
		// misaligned offset shares the link slot of the aligned one below
		issue(OP_RELEASE, 18'd3, 20'hFFFFF);
		issue(OP_RELEASE, 18'd3, 20'hFFFF0);
		issue(OP_ALLOC, 18'd3, 20'd0);
		// release of a block never granted wraps the class live count
		issue(OP_RELEASE, 18'd5, 20'h12345);
		issue(OP_ALLOC, 18'd5, 20'd0);
		issue(OP_STATS, 18'd5, 20'd0);
		issue(OP_NONE, 18'd7, 20'hABCDE);
		issue(OP_ALLOC, 18'd131072, 20'h5A5A5);
		issue(OP_ALLOC, 18'd7, 20'd0);
		issue(OP_RELEASE, 18'd131072, 20'h00010);
		drain();

		// smallest arena, bump space runs out quickly
		set_register(CFG_MODE, 21'd1);
		set_register(CFG_ARENA, 21'd4096);
		run_phase(PHASE_ITEMS);
		drain();

		tx_idle_pct = 55;
		rx_idle_pct = 36;
		set_register(CFG_MODE, 21'd0);
		set_register(CFG_ARENA, 21'h1FFFFF);
		run_phase(PHASE_ITEMS);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_register(CFG_MODE, 21'd1);
		set_register(CFG_ARENA, CFG_DATA_W'(ARENA));
		run_phase(PHASE_ITEMS);
		drain();

		set_register(CFG_ARENA, CFG_DATA_W'($urandom_range(ARENA, 4096)));
		run_phase(PHASE_ITEMS);
		drain();

		if (ledger.failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
